// ===== hdl/mqd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mqd_pkg
// Shared types and constants of the message queue deque unit: request and
// response beats, request modes, response status codes, controller commands.
// ---------------------------------------------------------------------------
package mqd_pkg;

   localparam int MSG_W  = 32;
   localparam int CAP_W  = 5;
   localparam int MODE_W = 3;
   localparam int STAT_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [MODE_W-1:0] {
      MODE_SEND_BACK  = 3'd0,
      MODE_SEND_FRONT = 3'd1,
      MODE_OVERWRITE  = 3'd2,
      MODE_RECEIVE    = 3'd3,
      MODE_PEEK       = 3'd4,
      MODE_CLEAR      = 3'd5
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_PASS  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [MSG_W-1:0]  message_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [MSG_W-1:0]  message_out;
      logic [CAP_W-1:0]  fill_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic csr_write;
   } cmd_type;

endpackage : mqd_pkg
`default_nettype wire

// ===== hdl/mqd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mqd_ctrl
// Controller: sequences each request through capture and execute, and owns
// the response valid flag and the handshake ready signals.
// ---------------------------------------------------------------------------
module mqd_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   output mqd_pkg::cmd_type     cmd
);
   import mqd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      req_fire;
   logic      rsp_free;

   // A request may enter while a response waits; it then holds in execute until
   // the response register frees up.
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture   = req_fire;
   assign cmd.execute   = (state_ff == ST_EXEC) && rsp_free;
   assign cmd.csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_fire) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule : mqd_ctrl
`default_nettype wire

// ===== hdl/mqd_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mqd_dpath
// Datapath: message ring memory, ring pointers, fill counter, capacity
// register and the response register.
// ---------------------------------------------------------------------------
module mqd_dpath #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mqd_pkg::cmd_type             cmd,
   input  wire mqd_pkg::req_type             req_payload,
   input  wire logic [mqd_pkg::CAP_W-1:0]    csr_data,
   output mqd_pkg::rsp_type                  rsp_payload
);
   import mqd_pkg::*;

   localparam int IW   = $clog2(DEPTH);
   localparam int XW   = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;
   localparam int MAXW = (WIDTH > MSG_W) ? WIDTH : MSG_W;

   // Capacity as used: zero acts as one, anything above the ring depth as the depth.
   function automatic logic [CAP_W-1:0] eff_of(input logic [CAP_W-1:0] c);
      if (c == '0) begin
         return CAP_W'(1);
      end else if (32'(c) > 32'(DEPTH)) begin
         return CAP_W'(DEPTH);
      end else begin
         return c;
      end
   endfunction

   function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i,
                                              input logic [CAP_W-1:0] e);
      logic [XW-1:0] ip1;
      ip1 = XW'(i) + XW'(1);
      if (ip1 >= XW'(e)) begin
         return '0;
      end else begin
         return ip1[IW-1:0];
      end
   endfunction

   function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i,
                                              input logic [CAP_W-1:0] e);
      logic [CAP_W-1:0] em1;
      em1 = e - CAP_W'(1);
      if (i == '0 || XW'(i) >= XW'(e)) begin
         return IW'(em1);
      end else begin
         return i - IW'(1);
      end
   endfunction

   logic [WIDTH-1:0]  mem [DEPTH];
   logic [WIDTH-1:0]  rdata_ff;
   logic [IW-1:0]     raddr;

   logic [CAP_W-1:0]  cap_ff;
   logic [CAP_W-1:0]  count_ff, count_in;
   logic [IW-1:0]     wr_ff, wr_in;
   logic [IW-1:0]     rd_ff, rd_in;
   logic [MODE_W-1:0] mode_ff;
   logic [MSG_W-1:0]  msg_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [CAP_W-1:0]  eff;
   logic [CAP_W-1:0]  eff_new;
   logic              full;
   logic              empty;
   logic              we;
   logic [IW-1:0]     waddr;
   logic [MAXW-1:0]   wide_in;
   logic [MAXW-1:0]   wide_out;
   logic [WIDTH-1:0]  wdata;

   assign eff     = eff_of(cap_ff);
   assign eff_new = eff_of(csr_data);
   assign full    = (count_ff >= eff);
   assign empty   = (count_ff == '0);
   assign raddr   = idx_next(rd_ff, eff);

   // Messages are held at WIDTH bits; the beat carries a fixed 32-bit word.
   always_comb begin
      wide_in = '0;
      wide_in[MSG_W-1:0] = msg_ff;
      wide_out = '0;
      wide_out[WIDTH-1:0] = rdata_ff;
   end
   assign wdata = wide_in[WIDTH-1:0];

   always_comb begin
      count_in            = count_ff;
      wr_in               = wr_ff;
      rd_in               = rd_ff;
      we                  = 1'b0;
      waddr               = wr_ff;
      rsp_in.status       = STATUS_PASS;
      rsp_in.message_out  = '0;
      rsp_in.fill_count   = count_ff;
      unique case (mode_ff)
         MODE_SEND_BACK: begin
            if (full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               we       = 1'b1;
               waddr    = wr_ff;
               wr_in    = idx_next(wr_ff, eff);
               count_in = count_ff + CAP_W'(1);
            end
         end
         MODE_SEND_FRONT, MODE_OVERWRITE: begin
            if (full && mode_ff == MODE_SEND_FRONT) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               we    = 1'b1;
               waddr = rd_ff;
               rd_in = idx_prev(rd_ff, eff);
               // A full overwrite replaces the newest entry, which becomes the head.
               if (full) begin
                  count_in = eff;
                  wr_in    = idx_prev(wr_ff, eff);
               end else begin
                  count_in = count_ff + CAP_W'(1);
               end
            end
         end
         MODE_RECEIVE, MODE_PEEK: begin
            if (empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.message_out = wide_out[MSG_W-1:0];
               if (mode_ff == MODE_RECEIVE) begin
                  rd_in    = raddr;
                  count_in = count_ff - CAP_W'(1);
               end
            end
         end
         MODE_CLEAR: begin
            count_in = '0;
            wr_in    = '0;
            rd_in    = IW'(eff - CAP_W'(1));
         end
         default: begin
         end
      endcase
      rsp_in.fill_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.capture) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_payload.mode;
         msg_ff  <= req_payload.message_in;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
         wr_ff    <= '0;
         rd_ff    <= IW'(eff_of(CAP_RESET) - CAP_W'(1));
      end else if (cmd.csr_write) begin
         // A capacity write also empties the queue; slot contents stay.
         cap_ff   <= csr_data;
         count_ff <= '0;
         wr_ff    <= '0;
         rd_ff    <= IW'(eff_new - CAP_W'(1));
      end else if (cmd.execute) begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule : mqd_dpath
`default_nettype wire

// ===== hdl/message_queue_deque_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// message_queue_deque_unit
// Hardware mailbox: a ring of up to DEPTH messages used as a deque, with
// send back, send front, overwrite, receive, peek and clear requests.
// ---------------------------------------------------------------------------
// Usage:
//   Each request beat on req_ (mode, message_in) yields exactly one response
//   beat on rsp_ (status, message_out, fill_count). Send modes report full,
//   receive and peek report empty; overwrite always passes.
//   A request passes through capture, which reads the head slot from the ring
//   memory, whose read port is registered, and then execute, which updates the
//   pointers and loads the response register. rsp_valid rises after execute,
//   and req_ready stays low in execute, so requests do not overlap there.
//   The response register lets the next request enter while the previous
//   response waits; that request then holds in execute, with req_ready low,
//   until the waiting response is taken.
//   csr_ writes the capacity register and empties the queue; write it only
//   while no request is in flight.
//   Reset zeroes the count and write pointer, sets capacity to 16 and the read
//   pointer to the last slot in use. Slots are not cleared; none unwritten is returned.
// ---------------------------------------------------------------------------
module message_queue_deque_unit #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire mqd_pkg::req_type             req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output mqd_pkg::rsp_type                  rsp_payload,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [mqd_pkg::CAP_W-1:0]    csr_data
);
   import mqd_pkg::*;

   cmd_type cmd;

   mqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   mqd_dpath #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule : message_queue_deque_unit
`default_nettype wire
